// ----- design/stun_pkg.sv -----
// ----------------------------------------------------------------------------
// stun_pkg
// Types, codes and lookup functions shared by the STUN message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stun_pkg;

   localparam int unsigned HEADER_BYTES = 20;
   localparam int unsigned POS_W        = 17;
   localparam int unsigned LEN_W        = 16;

   // walk phase
   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_ATTR_HDR = 2'd1,
      PH_ATTR_VAL = 2'd2,
      PH_STOP     = 2'd3
   } phase_type;

   // end record status
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_UNSUP    = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_OVERRUN  = 3'd4
   } status_type;

   // record kind on the result stream
   localparam logic REC_ATTR = 1'b0;
   localparam logic REC_END  = 1'b1;

   // message type words
   localparam logic [15:0] MT_REQUEST    = 16'h0001;
   localparam logic [15:0] MT_SUCCESS    = 16'h0101;
   localparam logic [15:0] MT_ERROR      = 16'h0111;
   localparam logic [15:0] MT_INDICATION = 16'h0011;

   // attribute type words
   localparam logic [15:0] AT_MAPPED        = 16'h0001;
   localparam logic [15:0] AT_XOR_MAPPED    = 16'h0020;
   localparam logic [15:0] AT_USERNAME      = 16'h0006;
   localparam logic [15:0] AT_INTEGRITY     = 16'h0008;
   localparam logic [15:0] AT_FINGERPRINT   = 16'h8028;
   localparam logic [15:0] AT_USE_CANDIDATE = 16'h0011;
   localparam logic [15:0] AT_CONTROLLING   = 16'h8029;
   localparam logic [15:0] AT_RELAYED       = 16'h0021;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } msg_kind_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] code;
   } attr_code_type;

   // one queue entry: the results caused by one input byte
   typedef struct packed {
      logic        has_attr;
      logic        has_end;
      logic [2:0]  attr_code;
      logic [15:0] attr_len;
      logic [16:0] attr_off;
      logic [15:0] msg_len;
      logic [1:0]  msg_kind;
      logic [2:0]  status;
      logic [31:0] txid_upper;
      logic [63:0] txid_lower;
   } rec_entry_type;

   function automatic msg_kind_type kind_of(input logic [15:0] t);
      msg_kind_type r;
      r = '{valid: 1'b1, kind: 2'd0};
      case (t)
         MT_REQUEST:    r.kind = 2'd0;
         MT_SUCCESS:    r.kind = 2'd1;
         MT_ERROR:      r.kind = 2'd2;
         MT_INDICATION: r.kind = 2'd3;
         default:       r.valid = 1'b0;
      endcase
      return r;
   endfunction

   function automatic attr_code_type code_of(input logic [15:0] t);
      attr_code_type r;
      r = '{valid: 1'b1, code: 3'd0};
      case (t)
         AT_MAPPED:        r.code = 3'd0;
         AT_XOR_MAPPED:    r.code = 3'd1;
         AT_USERNAME:      r.code = 3'd2;
         AT_INTEGRITY:     r.code = 3'd3;
         AT_FINGERPRINT:   r.code = 3'd4;
         AT_USE_CANDIDATE: r.code = 3'd5;
         AT_CONTROLLING:   r.code = 3'd6;
         AT_RELAYED:       r.code = 3'd7;
         default:          r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/stun_message_parser.sv -----
// ----------------------------------------------------------------------------
// stun_message_parser
// Byte-serial STUN header and attribute walker with a small result queue.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser        tlast
//  req_      in   data_byte                      -            end_of_datagram
//  rsp_      out  code,len,off,kind,status,txid  record_kind  last_of_run
//
//  One byte is taken per cycle while req_tready is high; its results land in
//  the queue at that edge and can leave the next cycle. A byte causes zero,
//  one or two results. The result side sends one record per cycle while
//  rsp_tready is high, so a byte that emits both an attribute and an end
//  record needs two transfers; the four-entry queue absorbs this and stalls
//  req_tready only when full. Reset (synchronous, active high) empties the
//  queue and returns the walk to the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_message_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,   // end_of_datagram
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [2:0] attr_code, [18:3] value_length, [35:19] value_offset,
   // [37:36] message_kind, [40:38] status, [72:41] txid_upper,
   // [136:73] txid_lower, [143:137] zero
   output      logic [143:0] rsp_tdata,
   output      logic         rsp_tuser,   // record_kind
   output      logic         rsp_tlast    // last_of_run
);

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QIDX_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // parse state
   logic [16:0]          pos_ff,  pos_in;
   logic [15:0]          type_ff, type_in;
   logic [15:0]          mlen_ff, mlen_in;
   logic [31:0]          txu_ff,  txu_in;
   logic [63:0]          txl_ff,  txl_in;
   logic [31:0]          hdr_ff,  hdr_in;
   logic [16:0]          ave_ff,  ave_in;
   stun_pkg::phase_type  phase_ff, phase_in;
   stun_pkg::status_type err_ff,  err_in;

   // result queue
   stun_pkg::rec_entry_type q_ff [QDEPTH];
   logic [QIDX_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]       cnt_ff;
   logic                    attr_sent_ff;

   logic                    req_acc, rsp_acc, push, pop;
   stun_pkg::rec_entry_type new_entry, head;
   stun_pkg::msg_kind_type  kind_now;
   stun_pkg::attr_code_type acode;
   stun_pkg::status_type    end_status;
   logic                    attr_hit;
   logic [16:0]             region_end;
   logic [17:0]             p1, vend, vend_pad;
   logic [31:0]             hdr_next;
   logic                    send_attr;

   assign req_tready = (cnt_ff != QCNT_W'(QDEPTH));
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // next state of the walk for the byte at the input
   always_comb begin
      pos_in     = pos_ff;
      type_in    = type_ff;
      mlen_in    = mlen_ff;
      txu_in     = txu_ff;
      txl_in     = txl_ff;
      hdr_in     = hdr_ff;
      ave_in     = ave_ff;
      phase_in   = phase_ff;
      err_in     = err_ff;
      attr_hit   = 1'b0;
      acode      = '{valid: 1'b0, code: 3'd0};
      region_end = 17'(stun_pkg::HEADER_BYTES) + {1'b0, mlen_ff};
      p1         = {1'b0, pos_ff} + 18'd1;
      hdr_next   = {hdr_ff[23:0], req_tdata};
      vend       = p1 + {2'b00, hdr_next[15:0]};
      vend_pad   = vend + 18'd3;
      end_status = stun_pkg::ST_OK;

      if (req_acc) begin
         case (phase_ff)
            stun_pkg::PH_HEADER: begin
               if (pos_ff < 17'd2) begin
                  type_in = {type_ff[7:0], req_tdata};
               end else if (pos_ff < 17'd4) begin
                  mlen_in = {mlen_ff[7:0], req_tdata};
               end else if (pos_ff >= 17'd8 && pos_ff < 17'd12) begin
                  txu_in = {txu_ff[23:0], req_tdata};
               end else if (pos_ff >= 17'd12 && pos_ff < 17'(stun_pkg::HEADER_BYTES)) begin
                  txl_in = {txl_ff[55:0], req_tdata};
               end
               if (pos_ff >= 17'(stun_pkg::HEADER_BYTES - 1)) begin
                  phase_in = stun_pkg::PH_ATTR_HDR;
               end
            end
            stun_pkg::PH_ATTR_HDR: begin
               if (pos_ff < region_end) begin
                  hdr_in = hdr_next;
                  // header complete on the fourth byte of each aligned word
                  if (pos_ff[1:0] == 2'b11) begin
                     if (vend > {1'b0, region_end}) begin
                        err_in   = stun_pkg::ST_OVERRUN;
                        phase_in = stun_pkg::PH_STOP;
                     end else begin
                        acode    = stun_pkg::code_of(hdr_next[31:16]);
                        attr_hit = acode.valid;
                        ave_in   = {vend_pad[16:2], 2'b00};
                        if (hdr_next[15:0] != 16'd0) begin
                           phase_in = stun_pkg::PH_ATTR_VAL;
                        end
                     end
                  end
               end
            end
            stun_pkg::PH_ATTR_VAL: begin
               if (p1 >= {1'b0, ave_ff}) begin
                  phase_in = stun_pkg::PH_ATTR_HDR;
               end
            end
            stun_pkg::PH_STOP: begin
            end
            default: begin
            end
         endcase
         if (pos_ff != '1) begin
            pos_in = pos_ff + 17'd1;
         end
      end

      kind_now = stun_pkg::kind_of(type_in);
      if (p1 < 18'(stun_pkg::HEADER_BYTES)) begin
         end_status = stun_pkg::ST_SHORT;
      end else if (!kind_now.valid) begin
         end_status = stun_pkg::ST_UNSUP;
      end else if (p1 < {1'b0, region_end}) begin
         end_status = stun_pkg::ST_MISMATCH;
      end else begin
         end_status = err_in;
      end

      new_entry.has_attr   = attr_hit;
      new_entry.has_end    = req_tlast;
      new_entry.attr_code  = acode.code;
      new_entry.attr_len   = hdr_next[15:0];
      new_entry.attr_off   = p1[16:0];
      new_entry.msg_len    = mlen_in;
      new_entry.msg_kind   = kind_now.kind;
      new_entry.status     = end_status;
      new_entry.txid_upper = txu_in;
      new_entry.txid_lower = txl_in;

      // end of datagram returns the walk to its reset state
      if (req_acc && req_tlast) begin
         pos_in   = '0;
         type_in  = '0;
         mlen_in  = '0;
         txu_in   = '0;
         txl_in   = '0;
         hdr_in   = '0;
         ave_in   = '0;
         phase_in = stun_pkg::PH_HEADER;
         err_in   = stun_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= '0;
         mlen_ff  <= '0;
         txu_ff   <= '0;
         txl_ff   <= '0;
         hdr_ff   <= '0;
         ave_ff   <= '0;
         phase_ff <= stun_pkg::PH_HEADER;
         err_ff   <= stun_pkg::ST_OK;
      end else begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         mlen_ff  <= mlen_in;
         txu_ff   <= txu_in;
         txl_ff   <= txl_in;
         hdr_ff   <= hdr_in;
         ave_ff   <= ave_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
      end
   end

   // result queue, one entry per byte that causes any record
   assign push      = req_acc && (attr_hit || req_tlast);
   assign head      = q_ff[rd_ptr_ff];
   assign send_attr = head.has_attr && !attr_sent_ff;
   assign pop       = rsp_acc && (!send_attr || !head.has_end);

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         attr_sent_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QIDX_W'(1);
         end
         if (pop) begin
            rd_ptr_ff    <= rd_ptr_ff + QIDX_W'(1);
            attr_sent_ff <= 1'b0;
         end else if (rsp_acc) begin
            attr_sent_ff <= 1'b1;
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = send_attr ? stun_pkg::REC_ATTR : stun_pkg::REC_END;
   assign rsp_tlast  = !send_attr || !head.has_end;
   assign rsp_tdata  = {7'd0,
                        head.txid_lower,
                        head.txid_upper,
                        send_attr ? 3'(stun_pkg::ST_OK) : head.status,
                        head.msg_kind,
                        send_attr ? head.attr_off : 17'd0,
                        send_attr ? head.attr_len : head.msg_len,
                        send_attr ? head.attr_code : 3'd0};

   // checks
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue count past depth");

   a_walk_clear : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> (pos_ff == '0 && phase_ff == stun_pkg::PH_HEADER))
      else $error("walk not cleared after end of datagram");

   a_head_live : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head.has_attr || head.has_end))
      else $error("queue head holds no record");

   a_attr_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == stun_pkg::REC_ATTR) |-> (rsp_tdata[40:38] == 3'd0))
      else $error("attribute record with nonzero status");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the STUN message parser. Datagrams are built
// byte by byte (well-formed, truncated, mislabeled, overrunning and noise) and
// streamed in with random gaps. A behavioral parser in the bench predicts the
// attribute and end records, which are compared field by field as they leave.
// ----------------------------------------------------------------------------

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POS_LIMIT    = 17'h1FFFF;
   localparam int unsigned DRAIN_LIMIT  = 4000;
   localparam int unsigned SETTLE       = 8;
   localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;

   typedef struct packed {
      logic        kind;
      logic [2:0]  code;
      logic [15:0] vlen;
      logic [16:0] voff;
      logic [1:0]  mkind;
      logic [2:0]  st;
      logic [31:0] txu;
      logic [63:0] txl;
      logic        lor;
   } stun_record_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   stun_message_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tlast  (req_tlast),    // end_of_datagram
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [2:0] code, [18:3] len, [35:19] off, [37:36] kind,
                                  // [40:38] status, [72:41] txid hi, [136:73] txid lo
      .rsp_tuser  (rsp_tuser),    // record_kind
      .rsp_tlast  (rsp_tlast)     // last_of_run
   );

   // parser state mirrored by the bench
   logic [16:0]          pos;
   logic [15:0]          mtype_w;
   logic [15:0]          msg_len;
   logic [31:0]          tx_hi;
   logic [63:0]          tx_lo;
   logic [31:0]          attr_hdr;
   logic [16:0]          val_end;
   stun_pkg::phase_type  phase;
   stun_pkg::status_type overrun_st;

   stun_record_type pending_records[$];
   logic [7:0]      wire_bytes[$];

   bit          quiet = 1'b0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned errors = 0;
   int unsigned byte_count = 0;
   int unsigned datagram_count = 0;
   int unsigned records_checked = 0;
   int unsigned attr_records = 0;
   int unsigned status_seen[5] = '{0, 0, 0, 0, 0};

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(60_000_000);
      $display("stun_message_parser regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int msg_kind_code(input logic [15:0] t);
      case (t)
         stun_pkg::MT_REQUEST:    return 0;
         stun_pkg::MT_SUCCESS:    return 1;
         stun_pkg::MT_ERROR:      return 2;
         stun_pkg::MT_INDICATION: return 3;
         default:                 return -1;
      endcase
   endfunction

   function automatic int attr_code_code(input logic [15:0] t);
      case (t)
         stun_pkg::AT_MAPPED:        return 0;
         stun_pkg::AT_XOR_MAPPED:    return 1;
         stun_pkg::AT_USERNAME:      return 2;
         stun_pkg::AT_INTEGRITY:     return 3;
         stun_pkg::AT_FINGERPRINT:   return 4;
         stun_pkg::AT_USE_CANDIDATE: return 5;
         stun_pkg::AT_CONTROLLING:   return 6;
         stun_pkg::AT_RELAYED:       return 7;
         default:                    return -1;
      endcase
   endfunction

   function automatic void clear_parse_state();
      pos        = '0;
      mtype_w    = '0;
      msg_len    = '0;
      tx_hi      = '0;
      tx_lo      = '0;
      attr_hdr   = '0;
      val_end    = '0;
      phase      = stun_pkg::PH_HEADER;
      overrun_st = stun_pkg::ST_OK;
   endfunction

   function automatic stun_record_type make_record(input logic kind, input logic [2:0] code,
                                                   input logic [15:0] vlen,
                                                   input logic [16:0] voff,
                                                   input logic [2:0] st);
      stun_record_type r;
      int mk;
      mk      = msg_kind_code(mtype_w);
      r.kind  = kind;
      r.code  = code;
      r.vlen  = vlen;
      r.voff  = voff;
      r.mkind = (mk < 0) ? 2'd0 : mk[1:0];
      r.st    = st;
      r.txu   = tx_hi;
      r.txl   = tx_lo;
      r.lor   = 1'b0;
      return r;
   endfunction

   task automatic parse_stun_byte(input logic [7:0] b, input logic is_last);
      stun_record_type      step_recs[$];
      int unsigned          p, region_end, vstart, alen;
      int                   code;
      stun_pkg::status_type st;
      p          = pos;
      region_end = stun_pkg::HEADER_BYTES + msg_len;
      case (phase)
         stun_pkg::PH_HEADER: begin
            if (p < 2)
               mtype_w = {mtype_w[7:0], b};
            else if (p < 4)
               msg_len = {msg_len[7:0], b};
            else if (p >= 8 && p < 12)
               tx_hi = {tx_hi[23:0], b};
            else if (p >= 12 && p < stun_pkg::HEADER_BYTES)
               tx_lo = {tx_lo[55:0], b};
            if (p >= stun_pkg::HEADER_BYTES - 1)
               phase = stun_pkg::PH_ATTR_HDR;
         end
         stun_pkg::PH_ATTR_HDR: begin
            if (p < region_end) begin
               attr_hdr = {attr_hdr[23:0], b};
               // header complete on the last byte of each aligned word
               if (p % 4 == 3) begin
                  vstart = p + 1;
                  alen   = 32'(attr_hdr[15:0]);
                  if (vstart + alen > region_end) begin
                     overrun_st = stun_pkg::ST_OVERRUN;
                     phase      = stun_pkg::PH_STOP;
                  end else begin
                     code = attr_code_code(attr_hdr[31:16]);
                     if (code >= 0)
                        step_recs = {step_recs,
                                     make_record(stun_pkg::REC_ATTR, code[2:0], alen[15:0],
                                                 vstart[16:0], stun_pkg::ST_OK)};
                     val_end = 17'((vstart + alen + 3) & ~32'd3);
                     if (alen != 0)
                        phase = stun_pkg::PH_ATTR_VAL;
                  end
               end
            end
         end
         stun_pkg::PH_ATTR_VAL: begin
            if (p + 1 >= val_end)
               phase = stun_pkg::PH_ATTR_HDR;
         end
         default: ;
      endcase
      if (pos < POS_LIMIT)
         pos = pos + 1'b1;
      if (is_last) begin
         if (p + 1 < stun_pkg::HEADER_BYTES)
            st = stun_pkg::ST_SHORT;
         else if (msg_kind_code(mtype_w) < 0)
            st = stun_pkg::ST_UNSUP;
         else if (p + 1 < region_end)
            st = stun_pkg::ST_MISMATCH;
         else
            st = overrun_st;
         step_recs = {step_recs, make_record(stun_pkg::REC_END, 3'd0, msg_len, 17'd0, st)};
         clear_parse_state();
      end
      if (step_recs.size() > 0)
         step_recs[step_recs.size() - 1].lor = 1'b1;
      pending_records = {pending_records, step_recs};
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at record %0d, %s: got %0h, expected %0h",
               records_checked, what, got, want);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin : check_records
      stun_record_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_records.size() == 0) begin
            report_mismatch("record with nothing pending", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_records.pop_front();
            compare_field("record_kind", 64'(rsp_tuser), 64'(want.kind));
            compare_field("attr_code", 64'(rsp_tdata[2:0]), 64'(want.code));
            compare_field("value_length", 64'(rsp_tdata[18:3]), 64'(want.vlen));
            compare_field("value_offset", 64'(rsp_tdata[35:19]), 64'(want.voff));
            compare_field("message_kind", 64'(rsp_tdata[37:36]), 64'(want.mkind));
            compare_field("status", 64'(rsp_tdata[40:38]), 64'(want.st));
            compare_field("txid_upper", 64'(rsp_tdata[72:41]), 64'(want.txu));
            compare_field("txid_lower", rsp_tdata[136:73], want.txl);
            compare_field("padding", 64'(rsp_tdata[143:137]), 64'd0);
            compare_field("last_of_run", 64'(rsp_tlast), 64'(want.lor));
            if (want.kind == stun_pkg::REC_END)
               status_seen[want.st]++;
            else
               attr_records++;
         end
         records_checked++;
      end
   end

   // result side: short random stalls, or a long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      parse_stun_byte(b, is_last);
      byte_count++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // sender goes quiet until every pending record has left or the drain limit is reached
   task automatic drain_records();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_records.size() != 0 && waited < DRAIN_LIMIT);
      if (pending_records.size() != 0) begin
         report_mismatch("records never arrived", 64'(pending_records.size()), 64'd0);
         pending_records.delete();
      end
   endtask

   function automatic logic [15:0] msg_type_at(input int unsigned i);
      case (i % 4)
         0:       return stun_pkg::MT_REQUEST;
         1:       return stun_pkg::MT_SUCCESS;
         2:       return stun_pkg::MT_ERROR;
         default: return stun_pkg::MT_INDICATION;
      endcase
   endfunction

   function automatic logic [15:0] attr_type_at(input int unsigned i);
      case (i % 8)
         0:       return stun_pkg::AT_MAPPED;
         1:       return stun_pkg::AT_XOR_MAPPED;
         2:       return stun_pkg::AT_USERNAME;
         3:       return stun_pkg::AT_INTEGRITY;
         4:       return stun_pkg::AT_FINGERPRINT;
         5:       return stun_pkg::AT_USE_CANDIDATE;
         6:       return stun_pkg::AT_CONTROLLING;
         default: return stun_pkg::AT_RELAYED;
      endcase
   endfunction

   function automatic logic [15:0] random_attr_type();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom);
      return attr_type_at($urandom_range(0, 7));
   endfunction

   function automatic int unsigned random_attr_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(13, 40);
      return $urandom_range(0, 12);
   endfunction

   task automatic append_byte(input logic [7:0] b);
      wire_bytes = {wire_bytes, b};
   endtask

   task automatic begin_message(input logic [15:0] mtype, input logic [95:0] txid);
      int i;
      wire_bytes.delete();
      append_byte(mtype[15:8]);
      append_byte(mtype[7:0]);
      append_byte(8'h00);
      append_byte(8'h00);
      for (i = 3; i >= 0; i--)
         append_byte(MAGIC_COOKIE[i*8 +: 8]);
      for (i = 11; i >= 0; i--)
         append_byte(txid[i*8 +: 8]);
   endtask

   task automatic add_noise(input int unsigned n);
      repeat (n) append_byte(8'($urandom));
   endtask

   task automatic add_attr_header(input logic [15:0] atype, input logic [15:0] l16);
      append_byte(atype[15:8]);
      append_byte(atype[7:0]);
      append_byte(l16[15:8]);
      append_byte(l16[7:0]);
   endtask

   // header, value and random padding up to the next word
   task automatic add_attr(input logic [15:0] atype, input int unsigned alen);
      add_attr_header(atype, 16'(alen));
      add_noise(alen);
      add_noise((4 - alen % 4) % 4);
   endtask

   // length field = bytes after the header so far, plus an offset
   task automatic set_length(input int delta);
      logic [15:0] l16;
      l16 = 16'(int'(wire_bytes.size()) - int'(stun_pkg::HEADER_BYTES) + delta);
      wire_bytes[2] = l16[15:8];
      wire_bytes[3] = l16[7:0];
   endtask

   task automatic send_message();
      int unsigned i, n;
      n = wire_bytes.size();
      for (i = 0; i < n; i++)
         send_byte(wire_bytes[i], i == n - 1);
      datagram_count++;
   endtask

   function automatic logic [95:0] random_txid();
      return {$urandom, $urandom, $urandom};
   endfunction

   task automatic random_message();
      int unsigned pick, cut;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         wire_bytes.delete();
         add_noise($urandom_range(1, 40));
      end else begin
         if (pick == 5)
            begin_message(16'($urandom), random_txid());
         else
            begin_message(msg_type_at($urandom_range(0, 3)), random_txid());
         repeat ($urandom_range(0, 4)) add_attr(random_attr_type(), random_attr_len());
         case (pick)
            2: set_length($urandom_range(1, 12));
            3: set_length(-int'($urandom_range(1, 8)));
            4: begin
               set_length(0);
               add_noise($urandom_range(1, 8));
            end
            6: begin
               add_noise($urandom_range(1, 3));
               set_length(0);
            end
            default: set_length(0);
         endcase
         if (pick == 1) begin
            cut = $urandom_range(1, wire_bytes.size() - 1);
            while (wire_bytes.size() > cut)
               void'(wire_bytes.pop_back());
         end
      end
      send_message();
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_message_kinds();
      int unsigned k;
      for (k = 0; k < 4; k++) begin
         begin_message(msg_type_at(k), random_txid());
         add_attr(attr_type_at(2 * k), $urandom_range(0, 5));
         add_attr(attr_type_at(2 * k + 1), $urandom_range(0, 5));
         set_length(0);
         send_message();
      end
      // txid extremes: all ones with header only, all zeros with one attribute
      begin_message(stun_pkg::MT_REQUEST, {96{1'b1}});
      set_length(0);
      send_message();
      begin_message(stun_pkg::MT_SUCCESS, 96'd0);
      add_attr(stun_pkg::AT_MAPPED, 4);
      set_length(0);
      send_message();
      drain_records();
   endtask

   task automatic test_short_datagrams();
      int unsigned cut;
      for (cut = 1; cut < stun_pkg::HEADER_BYTES; cut = cut * 2 + 1) begin
         begin_message(stun_pkg::MT_ERROR, random_txid());
         set_length(0);
         while (wire_bytes.size() > cut)
            void'(wire_bytes.pop_back());
         send_message();
      end
      drain_records();
   endtask

   task automatic test_unsupported_type();
      begin_message(16'h0000, random_txid());
      add_attr(stun_pkg::AT_USERNAME, 5);
      set_length(0);
      send_message();
      begin_message(16'hFFFF, random_txid());
      add_attr(stun_pkg::AT_RELAYED, 0);
      add_attr(stun_pkg::AT_CONTROLLING, 4);
      set_length(0);
      send_message();
      // unsupported wins over overrun
      begin_message(16'h0002, random_txid());
      add_attr(stun_pkg::AT_FINGERPRINT, 8);
      set_length(-8);
      send_message();
      drain_records();
   endtask

   task automatic test_attribute_walk();
      // unknown attribute between known ones is skipped
      begin_message(stun_pkg::MT_INDICATION, random_txid());
      add_attr(stun_pkg::AT_MAPPED, 3);
      add_attr(16'h1234, 5);
      add_attr(stun_pkg::AT_INTEGRITY, 8);
      set_length(0);
      send_message();
      // end arrives on the byte that completes a header: two records at once
      begin_message(stun_pkg::MT_REQUEST, random_txid());
      add_attr(stun_pkg::AT_USE_CANDIDATE, 0);
      set_length(0);
      send_message();
      // trailing partial header inside the region
      begin_message(stun_pkg::MT_SUCCESS, random_txid());
      add_attr(stun_pkg::AT_MAPPED, 8);
      add_noise(2);
      set_length(0);
      send_message();
      // bytes past the region are ignored
      begin_message(stun_pkg::MT_ERROR, random_txid());
      add_attr(stun_pkg::AT_XOR_MAPPED, 7);
      set_length(0);
      add_noise(5);
      send_message();
      drain_records();
   endtask

   task automatic test_length_errors();
      // too few bytes for the length field
      begin_message(stun_pkg::MT_REQUEST, random_txid());
      add_attr(stun_pkg::AT_USERNAME, 0);
      set_length(8);
      send_message();
      // value would run past the region
      begin_message(stun_pkg::MT_SUCCESS, random_txid());
      add_attr(stun_pkg::AT_XOR_MAPPED, 12);
      set_length(-4);
      add_noise(6);
      send_message();
      // largest attribute length always overruns, its value is never sent
      begin_message(stun_pkg::MT_INDICATION, random_txid());
      add_attr_header(stun_pkg::AT_CONTROLLING, 16'hFFFF);
      add_noise(5);
      set_length(0);
      send_message();
      drain_records();
   endtask

   task automatic test_backpressure();
      int unsigned k;
      rsp_hold_cycles = 60;
      begin_message(stun_pkg::MT_SUCCESS, random_txid());
      for (k = 0; k < 8; k++)
         add_attr(attr_type_at(k), 0);
      set_length(0);
      send_message();
      drain_records();
   endtask

   task automatic test_random_datagrams();
      int unsigned start;
      start = byte_count;
      while (byte_count - start < 80)
         random_message();
      drain_records();
   endtask

   task automatic test_back_to_back();
      int unsigned start;
      quiet = 1'b1;
      start = byte_count;
      while (byte_count - start < 50)
         random_message();
      drain_records();
   endtask

   initial begin
      clear_parse_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_message_kinds();
      test_short_datagrams();
      test_unsupported_type();
      test_attribute_walk();
      test_length_errors();
      test_backpressure();
      test_random_datagrams();
      test_back_to_back();

      repeat (SETTLE) @(posedge clock);
      $display("sent %0d datagrams in %0d bytes, checked %0d records (%0d attribute)",
               datagram_count, byte_count, records_checked, attr_records);
      $display("end status ok/short/unsupported/mismatch/overrun: %0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (errors == 0)
         $display("stun_message_parser regression: pass");
      else
         $display("stun_message_parser regression: fail");
      $finish;
   end

endmodule
